// ===== sv/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and codes of the priority thread scheduler
// Holds the operation, status, thread state and sequencer state encodings.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Default sizes of the thread table and the sleep counter.
  localparam int THREADS_DEF   = 16;
  localparam int TICK_BITS_DEF = 32;

  // Priority of thread zero after reset.
  localparam logic [1:0] LVL_NORMAL = 2'd2;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_ACTIVATE  = 3'd0,
    OP_SLEEP     = 3'd1,
    OP_TERMINATE = 3'd2,
    OP_TICK      = 3'd3,
    OP_IO_WAIT   = 3'd4,
    OP_IO_DONE   = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_STATE = 2'd1,
    STAT_BAD_PARAM = 2'd2
  } status_t;

  // Thread states as kept in the thread table.
  typedef enum logic [1:0] {
    TS_DEAD  = 2'd0,
    TS_READY = 2'd1,
    TS_RUN   = 2'd2,
    TS_WAIT  = 2'd3
  } tstate_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_ACT,
    S_TERM,
    S_IOD,
    S_RM_RD,
    S_RM_CK,
    S_TK_RD,
    S_TK_WR,
    S_PRE,
    S_DSP,
    S_DSP2,
    S_DONE
  } fsm_t;

endpackage

// ===== sv/priority_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_thread_scheduler: three level preemptive thread scheduler
// Thread table and ready queues live in two synchronous memories; a
// sequencer reads, modifies and writes them back for each item.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | opcode, thread_id, level, sleep_ticks
//  out_    | master    | running_id, idle_running, switched, status
//
//  One item is handled at a time. The thread table has one read port and
//  one write port; a tick reads it entry by entry in ascending order and
//  writes back each thread that is asleep on a nonzero count.
//  Reset is synchronous; valid bits stand in for the thread table's reset.
//  A result waits in the output register while out_tready is low; the next
//  item is taken once the result register has been loaded.
//
module priority_thread_scheduler #(
  parameter int THREADS   = pts_pkg::THREADS_DEF,
  parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], thread_id[6:3], level[8:7], sleep_ticks[40:9], zeros above
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // running_id[3:0], idle_running[4], switched[5], status[7:6]
  output logic [7:0]  out_tdata
);
  import pts_pkg::*;

  localparam int TW  = $clog2(THREADS);
  localparam int FW  = $clog2(THREADS + 1);
  localparam int QAW = $clog2(3 * THREADS);
  localparam int EW  = TICK_BITS + 4;

  // Sequencer and scheduler registers.
  fsm_t              state_r, state_nxt;
  logic [2:0]        op_r;
  logic [3:0]        tid_r;
  logic [1:0]        lv_r;
  logic [31:0]       ticks_r;
  logic [TW-1:0]     prev_run_r;
  logic              prev_idle_r;
  logic [TW-1:0]     run_r, run_nxt;
  logic              idle_r, idle_nxt;
  logic [1:0]        run_lvl_r, run_lvl_nxt;
  logic [TW-1:0]     head_r [3];
  logic [TW-1:0]     head_nxt [3];
  logic [FW-1:0]     fill_r [3];
  logic [FW-1:0]     fill_nxt [3];
  logic [TW:0]       idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic [1:0]        sv_lvl_r, sv_lvl_nxt;
  logic [1:0]        dq_r, dq_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r;
  logic [7:0]        out_data_r;
  logic              out_load;

  // Memories and their read registers.
  logic [EW-1:0]     tmem [THREADS];
  logic [THREADS-1:0] tvld_r;
  logic [EW-1:0]     tm_q_r;
  logic              tm_v_r, tm_a0_r;
  logic [TW-1:0]     qmem [3*THREADS];
  logic [TW-1:0]     qm_q_r;

  // Memory access controls.
  logic              tr_en, tw_en, qr_en, qw_en;
  logic [TW-1:0]     tr_addr, tw_addr, qw_data;
  logic [EW-1:0]     tw_data;
  logic [QAW-1:0]    qr_addr, qw_addr;
  logic              push_en;
  logic [TW-1:0]     push_id;
  logic [1:0]        push_lvl;

  // Decoded values.
  logic              in_acc;
  logic              id_ok;
  logic [TW-1:0]     tid_i;
  logic [TICK_BITS-1:0] sat_ticks;
  logic [63:0]       tk64;
  logic [EW-1:0]     e;
  tstate_t           e_st;
  logic [1:0]        e_lvl;
  logic [TICK_BITS-1:0] e_cnt;
  logic [1:0]        top_lvl;
  logic [1:0]        rq;

  function automatic logic [QAW-1:0] qaddr(input logic [1:0] q, input logic [TW-1:0] slot);
    qaddr = QAW'(QAW'(q) * QAW'(THREADS) + QAW'(slot));
  endfunction

  // Circular slot of a queue: head plus offset, offset never above THREADS.
  function automatic logic [TW-1:0] wrap(input logic [TW-1:0] h, input logic [TW:0] off);
    logic [TW+1:0] s;
    s = (TW+2)'(h) + (TW+2)'(off);
    if (s >= (TW+2)'(THREADS)) s = s - (TW+2)'(THREADS);
    wrap = TW'(s);
  endfunction

  function automatic logic [EW-1:0] mk(input tstate_t s, input logic [1:0] l,
                                       input logic [TICK_BITS-1:0] c);
    mk = {s, l, c};
  endfunction

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign id_ok = (int'(tid_r) < THREADS);
  assign tid_i = TW'(tid_r);
  assign tk64  = 64'(ticks_r);
  assign sat_ticks = ((tk64 >> TICK_BITS) != 64'd0) ? '1 : tk64[TICK_BITS-1:0];

  // An entry never written reads as its reset value.
  assign e = tm_v_r ? tm_q_r : (tm_a0_r ? mk(TS_RUN, LVL_NORMAL, '0) : '0);
  assign e_st  = tstate_t'(e[EW-1:EW-2]);
  assign e_lvl = e[EW-3:EW-4];
  assign e_cnt = e[TICK_BITS-1:0];

  // Highest level with a ready thread, zero when all queues are empty.
  assign top_lvl = (fill_r[2] != '0) ? 2'd3 :
                   (fill_r[1] != '0) ? 2'd2 :
                   (fill_r[0] != '0) ? 2'd1 : 2'd0;
  assign rq = sv_lvl_r - 2'd1;

  // Sequencer: next state, register updates and memory accesses.
  always_comb begin
    logic [1:0] pq;
    logic [1:0] dq;
    pq          = '0;
    dq          = '0;
    state_nxt   = state_r;
    run_nxt     = run_r;
    idle_nxt    = idle_r;
    run_lvl_nxt = run_lvl_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    sv_lvl_nxt  = sv_lvl_r;
    dq_nxt      = dq_r;
    status_nxt  = status_r;
    tr_en = 1'b0; tr_addr = '0;
    tw_en = 1'b0; tw_addr = '0; tw_data = '0;
    qr_en = 1'b0; qr_addr = '0;
    qw_en = 1'b0; qw_addr = '0; qw_data = '0;
    push_en = 1'b0; push_id = '0; push_lvl = '0;
    out_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          status_nxt = STAT_OK;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        unique case (op_r)
          OP_ACTIVATE: begin
            if (!id_ok || lv_r == 2'd0) begin
              status_nxt = STAT_BAD_PARAM;
              state_nxt  = S_DONE;
            end else begin
              tr_en = 1'b1; tr_addr = tid_i;
              state_nxt = S_ACT;
            end
          end
          OP_SLEEP: begin
            if (ticks_r == 32'd0) begin
              status_nxt = STAT_BAD_PARAM;
              state_nxt  = S_DONE;
            end else if (idle_r) begin
              status_nxt = STAT_BAD_STATE;
              state_nxt  = S_DONE;
            end else begin
              tw_en = 1'b1; tw_addr = run_r;
              tw_data = mk(TS_WAIT, run_lvl_r, sat_ticks);
              state_nxt = S_DSP;
            end
          end
          OP_TERMINATE: begin
            if (!id_ok) begin
              status_nxt = STAT_BAD_PARAM;
              state_nxt  = S_DONE;
            end else begin
              tr_en = 1'b1; tr_addr = tid_i;
              state_nxt = S_TERM;
            end
          end
          OP_TICK: begin
            idx_nxt   = '0;
            state_nxt = S_TK_RD;
          end
          OP_IO_WAIT: begin
            if (idle_r) begin
              status_nxt = STAT_BAD_STATE;
              state_nxt  = S_DONE;
            end else begin
              tw_en = 1'b1; tw_addr = run_r;
              tw_data = mk(TS_WAIT, run_lvl_r, '0);
              state_nxt = S_DSP;
            end
          end
          OP_IO_DONE: begin
            if (!id_ok) begin
              status_nxt = STAT_BAD_PARAM;
              state_nxt  = S_DONE;
            end else begin
              tr_en = 1'b1; tr_addr = tid_i;
              state_nxt = S_IOD;
            end
          end
          default: begin
            status_nxt = STAT_BAD_PARAM;
            state_nxt  = S_DONE;
          end
        endcase
      end
      // Activate: only a dead thread may be started.
      S_ACT: begin
        if (e_st != TS_DEAD) begin
          status_nxt = STAT_BAD_STATE;
          state_nxt  = S_DONE;
        end else begin
          tw_en = 1'b1; tw_addr = tid_i;
          tw_data = mk(TS_READY, lv_r, e_cnt);
          push_en = 1'b1; push_id = tid_i; push_lvl = lv_r;
          state_nxt = S_PRE;
        end
      end
      // Terminate: kill a live thread, then unlink it if ready or reschedule.
      S_TERM: begin
        if (e_st == TS_DEAD) begin
          status_nxt = STAT_BAD_STATE;
          state_nxt  = S_DONE;
        end else begin
          tw_en = 1'b1; tw_addr = tid_i;
          tw_data = mk(TS_DEAD, e_lvl, '0);
          if (e_st == TS_READY && e_lvl != 2'd0) begin
            sv_lvl_nxt = e_lvl;
            idx_nxt    = '0;
            found_nxt  = 1'b0;
            state_nxt  = S_RM_RD;
          end else if (e_st == TS_RUN && !idle_r && run_r == tid_i) begin
            state_nxt = S_DSP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      // Queue removal: walk the queue, sliding later entries down by one.
      S_RM_RD: begin
        if (idx_r == (TW+1)'(fill_r[rq])) begin
          if (found_r) fill_nxt[rq] = fill_r[rq] - FW'(1);
          state_nxt = S_DONE;
        end else begin
          qr_en = 1'b1;
          qr_addr = qaddr(rq, wrap(head_r[rq], idx_r));
          state_nxt = S_RM_CK;
        end
      end
      S_RM_CK: begin
        if (found_r) begin
          qw_en = 1'b1;
          qw_addr = qaddr(rq, wrap(head_r[rq], idx_r - (TW+1)'(1)));
          qw_data = qm_q_r;
        end else if (qm_q_r == tid_i) begin
          found_nxt = 1'b1;
        end
        idx_nxt   = idx_r + (TW+1)'(1);
        state_nxt = S_RM_RD;
      end
      // Io done: only a thread waiting on io becomes ready.
      S_IOD: begin
        if (e_st != TS_WAIT || e_cnt != '0) begin
          status_nxt = STAT_BAD_STATE;
          state_nxt  = S_DONE;
        end else begin
          tw_en = 1'b1; tw_addr = tid_i;
          tw_data = mk(TS_READY, e_lvl, '0);
          push_en = 1'b1; push_id = tid_i; push_lvl = e_lvl;
          state_nxt = S_PRE;
        end
      end
      // Tick sweep over the thread table in ascending order.
      S_TK_RD: begin
        if (idx_r == (TW+1)'(THREADS)) begin
          state_nxt = S_PRE;
        end else begin
          tr_en = 1'b1; tr_addr = idx_r[TW-1:0];
          state_nxt = S_TK_WR;
        end
      end
      S_TK_WR: begin
        if (e_st == TS_WAIT && e_cnt != '0) begin
          tw_en = 1'b1; tw_addr = idx_r[TW-1:0];
          if (e_cnt == TICK_BITS'(1)) begin
            tw_data = mk(TS_READY, e_lvl, '0);
            push_en = 1'b1; push_id = idx_r[TW-1:0]; push_lvl = e_lvl;
          end else begin
            tw_data = mk(TS_WAIT, e_lvl, e_cnt - TICK_BITS'(1));
          end
        end
        idx_nxt   = idx_r + (TW+1)'(1);
        state_nxt = S_TK_RD;
      end
      // Preemption: a strictly higher level displaces the running thread.
      S_PRE: begin
        if (idle_r) begin
          state_nxt = (top_lvl != 2'd0) ? S_DSP : S_DONE;
        end else if (top_lvl > run_lvl_r) begin
          tw_en = 1'b1; tw_addr = run_r;
          tw_data = mk(TS_READY, run_lvl_r, '0);
          push_en = 1'b1; push_id = run_r; push_lvl = run_lvl_r;
          state_nxt = S_DSP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // Dispatch: pop the head of the highest non-empty queue.
      S_DSP: begin
        if (top_lvl == 2'd0) begin
          idle_nxt  = 1'b1;
          run_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          dq = top_lvl - 2'd1;
          qr_en = 1'b1;
          qr_addr = qaddr(dq, head_r[dq]);
          head_nxt[dq] = wrap(head_r[dq], (TW+1)'(1));
          fill_nxt[dq] = fill_r[dq] - FW'(1);
          dq_nxt    = dq;
          state_nxt = S_DSP2;
        end
      end
      S_DSP2: begin
        tw_en = 1'b1; tw_addr = qm_q_r;
        tw_data = mk(TS_RUN, dq_r + 2'd1, '0);
        run_nxt     = qm_q_r;
        idle_nxt    = 1'b0;
        run_lvl_nxt = dq_r + 2'd1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Tail insert into the queue of the pushed thread's level.
    pq = push_lvl - 2'd1;
    if (push_en && push_lvl != 2'd0 && fill_r[pq] < FW'(THREADS)) begin
      qw_en   = 1'b1;
      qw_addr = qaddr(pq, wrap(head_r[pq], (TW+1)'(fill_r[pq])));
      qw_data = push_id;
      fill_nxt[pq] = fill_r[pq] + FW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      idle_r      <= 1'b0;
      run_lvl_r   <= LVL_NORMAL;
      head_r      <= '{default: '0};
      fill_r      <= '{default: '0};
      idx_r       <= '0;
      found_r     <= 1'b0;
      tvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      run_r     <= run_nxt;
      idle_r    <= idle_nxt;
      run_lvl_r <= run_lvl_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      found_r   <= found_nxt;
      if (tw_en) tvld_r[tw_addr] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Item fields, saved values and the result register.
  always_ff @(posedge clk) begin
    sv_lvl_r <= sv_lvl_nxt;
    dq_r     <= dq_nxt;
    status_r <= status_nxt;
    if (in_acc) begin
      op_r        <= in_tdata[2:0];
      tid_r       <= in_tdata[6:3];
      lv_r        <= in_tdata[8:7];
      ticks_r     <= in_tdata[40:9];
      prev_run_r  <= run_r;
      prev_idle_r <= idle_r;
    end
    if (out_load) begin
      out_data_r <= {status_r,
                     (idle_r != prev_idle_r) || (!idle_r && run_r != prev_run_r),
                     idle_r,
                     idle_r ? 4'd0 : 4'(run_r)};
    end
  end

  // Thread table memory.
  always_ff @(posedge clk) begin
    if (tw_en) tmem[tw_addr] <= tw_data;
    if (tr_en) begin
      tm_q_r  <= tmem[tr_addr];
      tm_v_r  <= tvld_r[tr_addr];
      tm_a0_r <= (tr_addr == '0);
    end
  end

  // Ready queue memory, three circular queues side by side.
  always_ff @(posedge clk) begin
    if (qw_en) qmem[qw_addr] <= qw_data;
    if (qr_en) qm_q_r <= qmem[qr_addr];
  end

endmodule

// ===== sv/pts_chk.sv =====
// ----------------------------------------------------------------------------
// pts_chk: port checker of the priority thread scheduler
// Watches the item channels and the result encoding over time.
// ----------------------------------------------------------------------------
module pts_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import pts_pkg::*;

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Items are handled one at a time.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // Idle reports thread zero.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3:0] == 4'd0)
    else $error("idle result with a thread id");

  // A rejected item never switches threads.
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] != STAT_OK |-> !out_tdata[5])
    else $error("rejected item switched threads");

  // Only defined status codes appear.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:6] == STAT_OK || out_tdata[7:6] == STAT_BAD_STATE ||
                   out_tdata[7:6] == STAT_BAD_PARAM)
    else $error("undefined status code");

endmodule

bind priority_thread_scheduler pts_chk u_pts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
